### hw/rtl/nww_pkg.sv
`default_nettype none
package nww_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_WINDOW = 64;
  localparam int COORD_BITS = 24;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WL_RESET = 7'd16;

  localparam int CMP_A = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_W = (CMP_A > WIN_W) ? CMP_A : WIN_W;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;

  localparam int OUT_IDX_W   = 10;
  localparam int OUT_DIST_W  = 50;
  localparam int OUT_COUNT_W = 7;

  localparam int S_TDATA_W = 2 * COORD_BITS;
  localparam int M_DATA_BITS = 2 + OUT_IDX_W + 2 * COORD_BITS + OUT_DIST_W + OUT_COUNT_W;
  localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                     kind;
    logic signed [COORD_BITS-1:0]  y;
    logic signed [COORD_BITS-1:0]  x;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_POINT = 1'b1
  } result_kind_t;

  // first member lands in the top bits, so status ends up at bit 0
  typedef struct packed {
    logic [OUT_COUNT_W-1:0]        window_count;
    logic [OUT_DIST_W-1:0]         nearest_distance;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_x;
    logic [OUT_IDX_W-1:0]          point_index;
    status_t                       status;
  } out_data_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_SCAN     = 3'd1,
    S_DRAIN    = 3'd2,
    S_EMIT_RD  = 3'd3,
    S_EMIT_OUT = 3'd4
  } back_state_t;

endpackage
`default_nettype wire

### hw/rtl/nww_front.sv
`default_nettype none
module nww_front
  import nww_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic [1:0]           s_tuser,
  output      logic                 push,
  output      cmd_t                 push_cmd,
  input  wire logic                 fifo_full
);

  logic      held;
  cmd_t      cmd;
  cmd_kind_t kind_in;

  always_comb begin
    if (s_tuser[0]) begin
      kind_in = CMD_QUERY;
    end else if (s_tuser[1]) begin
      kind_in = CMD_RESTART;
    end else begin
      kind_in = CMD_LOAD;
    end
  end

  assign push     = held && !fifo_full;
  assign push_cmd = cmd;
  assign s_tready = !held || !fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd.kind <= kind_in;
      cmd.x    <= s_tdata[COORD_BITS-1:0];
      cmd.y    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/nww_cmd_fifo.sv
`default_nettype none
module nww_cmd_fifo
  import nww_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      cmd_t head,
  output      logic empty
);

  cmd_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   fill;

  assign full  = (fill == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/nww_back.sv
`default_nettype none
module nww_back
  import nww_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data,
  input  wire cmd_t                 head,
  input  wire logic                 empty,
  output      logic                 pop,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [M_TDATA_W-1:0] m_tdata,
  output      logic [0:0]           m_tuser,
  output      logic                 m_tlast
);

  back_state_t state;
  back_state_t state_next;

  logic [CFG_W-1:0] window_length;
  logic [CNT_W-1:0] path_count;

  // waypoint store, {y, x}
  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_data;
  logic [IDX_W-1:0]        raddr;
  logic                    mem_we;
  logic [IDX_W-1:0]        waddr;

  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;

  logic [IDX_W-1:0] scan_addr;
  logic             v1;
  logic             v2;
  logic [IDX_W-1:0] idx1;
  logic [IDX_W-1:0] idx2;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;
  logic [SUM_W-1:0] dist_sum;
  logic [IDX_W-1:0] best;
  logic [SUM_W-1:0] best_dist;

  logic [WIN_W-1:0] win_n;
  logic [WIN_W-1:0] emit_i;
  logic [IDX_W-1:0] emit_addr;
  logic             emit_last;

  logic signed [COORD_BITS:0]     dx;
  logic signed [COORD_BITS:0]     dy;
  logic signed [2*COORD_BITS+1:0] prod_x;
  logic signed [2*COORD_BITS+1:0] prod_y;

  logic [CMP_W-1:0] wl_c;
  logic [CMP_W-1:0] wl_eff;
  logic [CMP_W-1:0] remain;
  logic [CMP_W-1:0] n_calc;

  logic             out_free;
  logic             out_load;
  out_data_t        out_word;
  result_kind_t     out_kind;
  logic             out_last;
  out_data_t        m_data;
  result_kind_t     m_kind;

  logic             is_load;
  logic [CNT_W-1:0] count_eff;
  logic             load_full;
  logic             scan_done;
  logic             drained;
  logic             start_scan;

  assign out_free  = !m_tvalid || m_tready;
  assign is_load   = (head.kind == CMD_LOAD) || (head.kind == CMD_RESTART);
  assign count_eff = (head.kind == CMD_RESTART) ? '0 : path_count;
  assign load_full = (count_eff >= CNT_W'(MAX_POINTS));
  assign waddr     = count_eff[IDX_W-1:0];
  assign scan_done = (CNT_W'(scan_addr) == path_count - CNT_W'(1));
  assign drained   = !v1 && !v2;
  assign emit_addr = best + IDX_W'(emit_i);
  assign emit_last = (emit_i == win_n - WIN_W'(1));
  assign raddr     = (state == S_SCAN) ? scan_addr : emit_addr;

  // squared distance terms
  assign dx = $signed({qx[COORD_BITS-1], qx})
            - $signed({rd_data[COORD_BITS-1], rd_data[COORD_BITS-1:0]});
  assign dy = $signed({qy[COORD_BITS-1], qy})
            - $signed({rd_data[2*COORD_BITS-1], rd_data[2*COORD_BITS-1:COORD_BITS]});
  assign prod_x   = dx * dx;
  assign prod_y   = dy * dy;
  assign dist_sum = SUM_W'(sq_x) + SUM_W'(sq_y);

  // window size: zero means one, clamp to the window limit, stop at path end
  assign wl_c   = CMP_W'(window_length);
  assign wl_eff = (wl_c == '0) ? CMP_W'(1)
                : (wl_c > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : wl_c;
  assign remain = CMP_W'(path_count - CNT_W'(best));
  assign n_calc = (remain > wl_eff) ? wl_eff : remain;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!empty && head.kind == CMD_QUERY && path_count != '0) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          state_next = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    start_scan = 1'b0;
    out_kind   = KIND_ACK;
    out_last   = 1'b1;
    out_word   = '0;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          if (is_load) begin
            out_word.point_x = head.x;
            out_word.point_y = head.y;
            if (out_free) begin
              pop      = 1'b1;
              out_load = 1'b1;
              if (load_full) begin
                out_word.status = ST_FULL;
              end else begin
                mem_we                = 1'b1;
                out_word.status       = ST_OK;
                out_word.point_index  = OUT_IDX_W'(count_eff);
              end
            end
          end else if (path_count == '0) begin
            if (out_free) begin
              pop             = 1'b1;
              out_load        = 1'b1;
              out_word.status = ST_EMPTY;
            end
          end else begin
            pop        = 1'b1;
            start_scan = 1'b1;
          end
        end
      end
      S_EMIT_OUT: begin
        out_load                  = out_free;
        out_kind                  = KIND_POINT;
        out_last                  = emit_last;
        out_word.status           = ST_OK;
        out_word.point_index      = OUT_IDX_W'(emit_addr);
        out_word.point_x          = rd_data[COORD_BITS-1:0];
        out_word.point_y          = rd_data[2*COORD_BITS-1:COORD_BITS];
        out_word.nearest_distance = OUT_DIST_W'(best_dist);
        out_word.window_count     = OUT_COUNT_W'(win_n);
      end
      S_SCAN, S_DRAIN, S_EMIT_RD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WL_RESET;
      path_count    <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      if (mem_we) begin
        path_count <= count_eff + CNT_W'(1);
      end
      v1 <= (state == S_SCAN);
      v2 <= v1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= {head.y, head.x};
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      qx        <= head.x;
      qy        <= head.y;
      scan_addr <= '0;
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
    idx1 <= scan_addr;
    idx2 <= idx1;
    sq_x <= prod_x[SQ_W-1:0];
    sq_y <= prod_y[SQ_W-1:0];
    // strict less-than keeps the lowest index on a tie
    if (v2 && (idx2 == '0 || dist_sum < best_dist)) begin
      best      <= idx2;
      best_dist <= dist_sum;
    end
    if (state == S_DRAIN && drained) begin
      win_n  <= WIN_W'(n_calc);
      emit_i <= '0;
    end else if (state == S_EMIT_OUT && out_free) begin
      emit_i <= emit_i + WIN_W'(1);
    end
    if (out_load) begin
      m_data  <= out_word;
      m_kind  <= out_kind;
      m_tlast <= out_last;
    end
  end

  assign m_tdata    = {{(M_TDATA_W - M_DATA_BITS){1'b0}}, m_data};
  assign m_tuser[0] = m_kind;

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> path_count != '0 && CNT_W'(scan_addr) < path_count)
    else $error("scan address beyond stored path");

  a_emit_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT_OUT |-> win_n != '0 && emit_i < win_n)
    else $error("emit index outside window");

  a_load_acked: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> out_load && pop)
    else $error("stored waypoint without acknowledgement");

  a_window_set: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN && drained |=> state == S_EMIT_RD && win_n != '0
      && CNT_W'(best) < path_count)
    else $error("empty window or nearest index out of path");

endmodule
`default_nettype wire

### hw/rtl/nearest_waypoint_window_core.sv
// Nearest waypoint window.
// Slave stream: s_tdata = {pos_y, pos_x}, s_tuser = {first_point, action}.
// action 0 appends a waypoint (first_point restarts the path), action 1
// queries with a vehicle position.
// Master stream: m_tuser = result_kind, m_tlast = last; m_tdata carries
// status, point_index, point_x, point_y, nearest_distance, window_count.
// A load answers with one ack word; loads are taken one per cycle while the
// output is not stalled. A query scans the store through one memory read
// port, one waypoint per cycle, then reads and puts out the window word by
// word: the nearest point and those after it, window_length words at most.
// A command queue of 4 words sits between the input stage and the engine;
// until it is full, input is taken while the engine scans or output stalls.
// A stalled receiver holds the output register; the engine then waits.
// Reset empties the path, sets window_length to 16 and drops queued words.
// cfg_wr_en / cfg_wr_data write window_length; write only while idle.
`default_nettype none
module nearest_waypoint_window_core
  import nww_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // pos_x, pos_y
  input  wire logic [1:0]           s_tuser,  // action, first_point
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  // status, point_index, point_x, point_y, nearest_distance, window_count, zero pad
  output      logic [M_TDATA_W-1:0] m_tdata,
  output      logic [0:0]           m_tuser,  // result_kind
  output      logic                 m_tlast,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_W-1:0]     cfg_wr_data
);

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic pop;
  cmd_t head;
  logic empty;

  nww_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  nww_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  nww_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule
`default_nettype wire
